// ===== rtl/core/cabac_pkg.sv =====
package cabac_pkg;

   localparam int DEF_NUM_CONTEXTS = 256;
   localparam int DEF_BUFFER_BITS  = 32;

   localparam logic [8:0] FULL_RANGE  = 9'd510;
   localparam logic [8:0] TERM_LPS    = 9'd2;
   localparam logic [5:0] MAX_STATE   = 6'd62;
   localparam logic [5:0] QP_RESET    = 6'd26;
   localparam logic [5:0] QP_MAX      = 6'd51;

   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_START = 3'd1,
      OP_INIT  = 3'd2,
      OP_LOAD  = 3'd3,
      OP_CTX   = 3'd4,
      OP_BYP   = 3'd5,
      OP_TERM  = 3'd6
   } op_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_STARVED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
   } dp_stat_type;

   localparam logic [7:0] LPS_TABLE [0:62][0:3] = '{
      '{8'd128,8'd176,8'd208,8'd240},'{8'd128,8'd167,8'd197,8'd227},
      '{8'd128,8'd158,8'd187,8'd216},'{8'd123,8'd150,8'd178,8'd205},
      '{8'd116,8'd142,8'd169,8'd195},'{8'd111,8'd135,8'd160,8'd185},
      '{8'd105,8'd128,8'd152,8'd175},'{8'd100,8'd122,8'd144,8'd166},
      '{8'd95,8'd116,8'd137,8'd158},'{8'd90,8'd110,8'd130,8'd150},
      '{8'd85,8'd104,8'd123,8'd142},'{8'd81,8'd99,8'd117,8'd135},
      '{8'd77,8'd94,8'd111,8'd128},'{8'd73,8'd89,8'd105,8'd122},
      '{8'd69,8'd85,8'd100,8'd116},'{8'd66,8'd80,8'd95,8'd110},
      '{8'd62,8'd76,8'd90,8'd104},'{8'd59,8'd72,8'd86,8'd99},
      '{8'd56,8'd69,8'd81,8'd94},'{8'd53,8'd65,8'd77,8'd89},
      '{8'd51,8'd62,8'd73,8'd85},'{8'd48,8'd59,8'd69,8'd80},
      '{8'd46,8'd56,8'd66,8'd76},'{8'd43,8'd53,8'd63,8'd72},
      '{8'd41,8'd50,8'd59,8'd69},'{8'd39,8'd48,8'd56,8'd65},
      '{8'd37,8'd45,8'd54,8'd62},'{8'd35,8'd43,8'd51,8'd59},
      '{8'd33,8'd41,8'd48,8'd56},'{8'd32,8'd39,8'd46,8'd53},
      '{8'd30,8'd37,8'd43,8'd50},'{8'd29,8'd35,8'd41,8'd48},
      '{8'd27,8'd33,8'd39,8'd45},'{8'd26,8'd31,8'd37,8'd43},
      '{8'd24,8'd30,8'd35,8'd41},'{8'd23,8'd28,8'd33,8'd39},
      '{8'd22,8'd27,8'd32,8'd37},'{8'd21,8'd26,8'd30,8'd35},
      '{8'd20,8'd24,8'd29,8'd33},'{8'd19,8'd23,8'd27,8'd31},
      '{8'd18,8'd22,8'd26,8'd30},'{8'd17,8'd21,8'd25,8'd28},
      '{8'd16,8'd20,8'd23,8'd27},'{8'd15,8'd19,8'd22,8'd25},
      '{8'd14,8'd18,8'd21,8'd24},'{8'd14,8'd17,8'd20,8'd23},
      '{8'd13,8'd16,8'd19,8'd22},'{8'd12,8'd15,8'd18,8'd21},
      '{8'd12,8'd14,8'd17,8'd20},'{8'd11,8'd14,8'd16,8'd19},
      '{8'd11,8'd13,8'd15,8'd18},'{8'd10,8'd12,8'd15,8'd17},
      '{8'd10,8'd12,8'd14,8'd16},'{8'd9,8'd11,8'd13,8'd15},
      '{8'd9,8'd11,8'd12,8'd14},'{8'd8,8'd10,8'd12,8'd14},
      '{8'd8,8'd9,8'd11,8'd13},'{8'd7,8'd9,8'd11,8'd12},
      '{8'd7,8'd9,8'd10,8'd12},'{8'd7,8'd8,8'd10,8'd11},
      '{8'd6,8'd8,8'd9,8'd11},'{8'd6,8'd7,8'd9,8'd10},
      '{8'd6,8'd7,8'd8,8'd9}
   };

   localparam logic [5:0] NEXT_LPS [0:62] = '{
      6'd0,6'd0,6'd1,6'd2,6'd2,6'd4,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd9,6'd11,
      6'd11,6'd12,6'd13,6'd13,6'd15,6'd15,6'd16,6'd16,6'd18,6'd18,6'd19,6'd19,
      6'd21,6'd21,6'd22,6'd22,6'd23,6'd24,6'd24,6'd25,6'd26,6'd26,6'd27,6'd27,
      6'd28,6'd29,6'd29,6'd30,6'd30,6'd30,6'd31,6'd32,6'd32,6'd33,6'd33,6'd33,
      6'd34,6'd34,6'd35,6'd35,6'd35,6'd36,6'd36,6'd36,6'd37,6'd37,6'd37,6'd38,
      6'd38
   };

   // Number of left shifts that bring a 9-bit range back to 256 or above.
   function automatic logic [3:0] renorm_shifts(input logic [8:0] r);
      logic [3:0] s;
      s = 4'd9;
      for (int i = 0; i < 9; i++) begin
         if (r[i]) begin
            s = 4'(8 - i);
         end
      end
      return s;
   endfunction

endpackage

// ===== rtl/core/cabac_bin_decoder_top.sv =====
// CABAC binary arithmetic decoding engine.
// The req channel carries one command per transaction; req_tuser holds the
// opcode (push byte, start, init context, load context, context bin, bypass
// bin, terminate bin). Every command returns exactly one rsp transaction
// with the decoded bin in rsp_tdata bit 0 and a status code in rsp_tuser
// (ok, too few buffered bits with no change made, or buffer full with the
// pushed byte dropped).
// Each command is first captured, which also reads the context store, then
// committed, which computes and writes the engine update. The context store
// is a single-port-read RAM; a new command is accepted only after the
// previous one has committed. The result waits in an output register. If
// the receiver stalls, the next command is still accepted, but its commit
// waits until the result slot is free, so nothing is lost or reordered. The
// slice QP register is written through csr_wr_en/csr_wr_data; the user must
// do so only while the block is idle, which the block does not enforce.
// Reset sets range to 510, clears offset and the bit buffer, and sets slice
// QP to 26; context entries are undefined until written.
module cabac_bin_decoder_top
   import cabac_pkg::*;
#(
   parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS,
   parameter int BUFFER_BITS  = DEF_BUFFER_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // context_index[7:0], byte_value[15:8], init_value[23:16],
   // load_state[29:24], load_mps[30], zero[31]
   input  logic [31:0] req_tdata,
   // opcode[2:0]
   input  logic [2:0]  req_tuser,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // bin_value[0], zero[7:1]
   output logic [7:0]  rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // Sequencer: capture, then commit when the output slot allows it.
   cabac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Engine registers, bit buffer, context store and result register.
   cabac_dp #(
      .NUM_CONTEXTS (NUM_CONTEXTS),
      .BUFFER_BITS  (BUFFER_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

// ===== rtl/core/cabac_ram.sv =====
module cabac_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/cabac_ctrl.sv =====
module cabac_ctrl
   import cabac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // The context read is back; finish once the result slot is free.
            if (stat.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/cabac_dp.sv =====
module cabac_dp
   import cabac_pkg::*;
#(
   parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS,
   parameter int BUFFER_BITS  = DEF_BUFFER_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic [31:0]  req_tdata,
   input  logic [2:0]   req_tuser,
   input  logic         csr_wr_en,
   input  logic [5:0]   csr_wr_data,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   localparam int AW = $clog2(NUM_CONTEXTS);
   localparam int CW = $clog2(BUFFER_BITS + 1);

   // Captured item.
   op_type           op_ff;
   logic [AW-1:0]    addr_ff;
   logic [7:0]       byte_ff;
   logic [7:0]       init_ff;
   logic [5:0]       lstate_ff;
   logic             lmps_ff;

   // Engine state.
   logic [5:0]             qp_ff;
   logic [8:0]             range_ff, range_in;
   logic [8:0]             off_ff, off_in;
   logic [BUFFER_BITS-1:0] buf_ff, buf_in;
   logic [CW-1:0]          cnt_ff, cnt_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic       bin_ff, bin_in;
   logic [1:0] status_ff, status_in;

   logic          mem_we;
   logic [6:0]    mem_wdata;
   logic [6:0]    mem_rdata;
   logic [9:0]    ci_ext;
   logic [AW-1:0] rd_addr;

   // Context index modulo the store depth; the index is below twice the depth.
   always_comb begin
      ci_ext = {2'b00, req_tdata[7:0]};
      if (ci_ext >= 10'(NUM_CONTEXTS)) begin
         ci_ext = ci_ext - 10'(NUM_CONTEXTS);
      end
      rd_addr = ci_ext[AW-1:0];
   end

   cabac_ram #(
      .WIDTH (7),
      .DEPTH (NUM_CONTEXTS)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (addr_ff),
      .wr_data (mem_wdata),
      .rd_en   (cmd.capture),
      .rd_addr (rd_addr),
      .rd_data (mem_rdata)
   );

   // Next 9 stream bits, MSB first, zero padded when fewer are buffered.
   logic [BUFFER_BITS+8:0] wide;
   logic [8:0]             win;
   assign wide = {buf_ff, 9'b0} >> cnt_ff;
   assign win  = wide[8:0];

   // Context decode.
   logic [5:0]  c_st, c_st_new;
   logic        c_mps, c_mps_new, c_lps_path;
   logic [7:0]  c_lps;
   logic [8:0]  c_rmps, c_r, c_off;
   logic [3:0]  c_need;

   // Context initialisation.
   logic [7:0]         m_u, n_u;
   logic [5:0]         qpc;
   logic signed [12:0] m13, qp13, prod, q13, pre;
   logic [6:0]         pre7;
   logic               i_mps;
   logic [5:0]         i_st;

   // Terminate and bypass.
   logic [8:0]  t_r;
   logic        t_need;
   logic [9:0]  b_off;

   logic [3:0]  take;
   logic [CW:0] push_cnt;

   always_comb begin
      c_st       = (mem_rdata[5:0] > MAX_STATE) ? MAX_STATE : mem_rdata[5:0];
      c_mps      = mem_rdata[6];
      c_lps      = LPS_TABLE[c_st][range_ff[7:6]];
      c_rmps     = range_ff - {1'b0, c_lps};
      c_lps_path = off_ff >= c_rmps;
      c_r        = c_lps_path ? {1'b0, c_lps} : c_rmps;
      c_off      = c_lps_path ? (off_ff - c_rmps) : off_ff;
      c_need     = renorm_shifts(c_r);
      if (c_lps_path) begin
         c_mps_new = (c_st == 6'd0) ? ~c_mps : c_mps;
         c_st_new  = NEXT_LPS[c_st];
      end else begin
         c_mps_new = c_mps;
         c_st_new  = (c_st < MAX_STATE) ? c_st + 6'd1 : c_st;
      end

      m_u  = {4'b0, init_ff[7:4]} * 8'd5 - 8'd45;
      n_u  = {1'b0, init_ff[3:0], 3'b0} - 8'd16;
      qpc  = (qp_ff > QP_MAX) ? QP_MAX : qp_ff;
      m13  = 13'(signed'(m_u));
      qp13 = signed'({7'b0, qpc});
      prod = m13 * qp13;
      q13  = prod >>> 4;
      pre  = q13 + 13'(signed'(n_u));
      if (pre < 13'sd1) begin
         pre7 = 7'd1;
      end else if (pre > 13'sd126) begin
         pre7 = 7'd126;
      end else begin
         pre7 = pre[6:0];
      end
      i_mps = pre7 > 7'd63;
      i_st  = i_mps ? 6'(pre7 - 7'd64) : 6'(7'd63 - pre7);

      t_r    = range_ff - TERM_LPS;
      t_need = ~t_r[8];
      b_off  = {off_ff, win[8]};

      push_cnt = {1'b0, cnt_ff} + (CW+1)'(8);
   end

   always_comb begin
      range_in  = range_ff;
      off_in    = off_ff;
      buf_in    = buf_ff;
      cnt_in    = cnt_ff;
      bin_in    = 1'b0;
      status_in = ST_OK;
      mem_we    = 1'b0;
      mem_wdata = '0;
      take      = 4'd0;
      case (op_ff)
         OP_PUSH: begin
            if (push_cnt > (CW+1)'(BUFFER_BITS)) begin
               status_in = ST_FULL;
            end else begin
               buf_in = {buf_ff[BUFFER_BITS-9:0], byte_ff};
               cnt_in = push_cnt[CW-1:0];
            end
         end
         OP_START: begin
            if (cnt_ff < CW'(9)) begin
               status_in = ST_STARVED;
            end else begin
               range_in = FULL_RANGE;
               off_in   = win;
               take     = 4'd9;
            end
         end
         OP_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = {i_mps, i_st};
         end
         OP_LOAD: begin
            mem_we    = 1'b1;
            mem_wdata = {lmps_ff, (lstate_ff > MAX_STATE) ? MAX_STATE : lstate_ff};
         end
         OP_CTX: begin
            if (range_ff[8]) begin
               if (CW'(c_need) > cnt_ff) begin
                  status_in = ST_STARVED;
               end else begin
                  mem_we    = 1'b1;
                  mem_wdata = {c_mps_new, c_st_new};
                  range_in  = 9'(c_r << c_need);
                  off_in    = 9'({c_off, win} >> (4'd9 - c_need));
                  bin_in    = c_mps ^ c_lps_path;
                  take      = c_need;
               end
            end
         end
         OP_BYP: begin
            if (range_ff[8]) begin
               if (cnt_ff == '0) begin
                  status_in = ST_STARVED;
               end else begin
                  take = 4'd1;
                  if (b_off >= {1'b0, range_ff}) begin
                     bin_in = 1'b1;
                     off_in = 9'(b_off - {1'b0, range_ff});
                  end else begin
                     off_in = b_off[8:0];
                  end
               end
            end
         end
         OP_TERM: begin
            if (range_ff[8]) begin
               if (off_ff >= t_r) begin
                  range_in = t_r;
                  bin_in   = 1'b1;
               end else if (t_need && (cnt_ff == '0)) begin
                  status_in = ST_STARVED;
               end else if (t_need) begin
                  range_in = {t_r[7:0], 1'b0};
                  off_in   = {off_ff[7:0], win[8]};
                  take     = 4'd1;
               end else begin
                  range_in = t_r;
               end
            end
         end
         default: begin
         end
      endcase
      if (take != 4'd0) begin
         cnt_in = cnt_ff - CW'(take);
         buf_in = buf_ff & ~({BUFFER_BITS{1'b1}} << cnt_in);
      end
      if (!cmd.commit) begin
         mem_we = 1'b0;
      end
   end

   assign stat.slot_free = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= op_type'(req_tuser);
         addr_ff   <= rd_addr;
         byte_ff   <= req_tdata[15:8];
         init_ff   <= req_tdata[23:16];
         lstate_ff <= req_tdata[29:24];
         lmps_ff   <= req_tdata[30];
      end
      if (cmd.commit) begin
         bin_ff    <= bin_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff        <= QP_RESET;
         range_ff     <= FULL_RANGE;
         off_ff       <= '0;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            qp_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            range_ff <= range_in;
            off_ff   <= off_in;
            buf_ff   <= buf_in;
            cnt_ff   <= cnt_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, bin_ff};
   assign rsp_tuser  = status_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(BUFFER_BITS))
      else $error("bit count exceeds buffer size");

   a_buf_clean: assert property (@(posedge clock) disable iff (reset)
      (buf_ff & ({BUFFER_BITS{1'b1}} << cnt_ff)) == '0)
      else $error("stale bits above the bit count");

   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("committed item produced no result");

   a_starved_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && status_in == ST_STARVED) |=>
         ($stable(range_ff) && $stable(off_ff) && $stable(cnt_ff)))
      else $error("starved transaction changed engine state");

   a_ctx_norm: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_CTX && range_ff[8] && status_in == ST_OK)
         |=> range_ff[8])
      else $error("range not renormalized after context bin");

endmodule
